// ===== hdl/sha256_stream_hasher_top_defines.svh =====
// Assertion macros used by the SHA-256 stream hasher RTL.
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define SHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SHS_ASSERT(lbl, prop, msg)
`define SHS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/shs_pkg.sv =====
// Types, constants and round functions of the SHA-256 stream hasher.
package shs_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dword_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== hdl/shs_fifo.sv =====
// Small first-in first-out queue used on both sides of the hash engine.
module shs_fifo #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r, rd_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

// ===== hdl/shs_core.sv =====
// Back end: block assembly, padding, 64-round compression and digest output.
`include "sha256_stream_hasher_top_defines.svh"
module shs_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  shs_pkg::item_t q_item,
  output logic           q_pop,
  input  logic           o_full,
  output logic           o_push,
  output shs_pkg::dword_t o_word
);
  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_RND  = 6'b000010,
    S_FIN  = 6'b000100,
    S_PAD  = 6'b001000,
    S_LEN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    AFT_NONE = 2'd0,
    AFT_EOM  = 2'd1,
    AFT_LEN  = 2'd2,
    AFT_OUT  = 2'd3
  } aft_t;

  state_t      state_r, state_nxt;
  aft_t        aft_r, aft_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [60:0] cnt_r, cnt_nxt;
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] h_r [8];
  logic [31:0] h_nxt [8];
  logic [63:0] bit_len;
  logic [31:0] t1, t2, wnew;

  assign bit_len = {cnt_r, 3'b000};
  assign t1 = v_r[7] + shs_pkg::big_sig1(v_r[4])
            + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + shs_pkg::RK[rnd_r] + w_r[0];
  assign t2 = shs_pkg::big_sig0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign wnew = shs_pkg::sml_sig1(w_r[14]) + w_r[9] + shs_pkg::sml_sig0(w_r[1]) + w_r[0];

  assign q_pop  = (state_r == S_LOAD) && !q_empty;
  assign o_push = (state_r == S_OUT) && !o_full;
  assign o_word = '{digest_word: h_r[idx_r], word_index: idx_r,
                    last_word: (idx_r == 3'd7)};

  always_comb begin
    state_nxt = state_r;
    aft_nxt   = aft_r;
    fill_nxt  = fill_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    w_nxt     = w_r;
    v_nxt     = v_r;
    h_nxt     = h_r;
    case (state_r)
      S_LOAD: begin
        if (!q_empty) begin
          if (q_item.byte_valid) begin
            w_nxt[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] = q_item.msg_byte;
            cnt_nxt  = cnt_r + 61'd1;
            fill_nxt = fill_r + 6'd1;
          end
          if (q_item.byte_valid && (fill_r == 6'd63)) begin
            v_nxt     = h_r;
            aft_nxt   = q_item.end_of_message ? AFT_EOM : AFT_NONE;
            state_nxt = S_RND;
          end else if (q_item.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_RND: begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = wnew;
        for (int i = 1; i < 8; i++) begin
          v_nxt[i] = v_r[i-1];
        end
        v_nxt[4] = v_r[3] + t1;
        v_nxt[0] = t1 + t2;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        case (aft_r)
          AFT_NONE: state_nxt = S_LOAD;
          AFT_EOM:  state_nxt = S_PAD;
          AFT_LEN:  state_nxt = S_LEN;
          AFT_OUT:  state_nxt = S_OUT;
          default:  state_nxt = S_LOAD;
        endcase
      end
      S_PAD: begin
        // Place the marker byte at the fill point and clear the rest.
        for (int p = 0; p < 64; p++) begin
          if (6'(p) == fill_r) begin
            w_nxt[p/4][(3 - p%4)*8 +: 8] = shs_pkg::PAD_BYTE;
          end else if (6'(p) > fill_r) begin
            w_nxt[p/4][(3 - p%4)*8 +: 8] = 8'h00;
          end
        end
        if (fill_r < shs_pkg::LEN_POS) begin
          w_nxt[14] = bit_len[63:32];
          w_nxt[15] = bit_len[31:0];
          aft_nxt   = AFT_OUT;
        end else begin
          aft_nxt   = AFT_LEN;
        end
        v_nxt     = h_r;
        state_nxt = S_RND;
      end
      S_LEN: begin
        for (int i = 0; i < 14; i++) begin
          w_nxt[i] = '0;
        end
        w_nxt[14] = bit_len[63:32];
        w_nxt[15] = bit_len[31:0];
        v_nxt     = h_r;
        aft_nxt   = AFT_OUT;
        state_nxt = S_RND;
      end
      S_OUT: begin
        if (!o_full) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            h_nxt     = shs_pkg::IV;
            cnt_nxt   = '0;
            fill_nxt  = '0;
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    v_r <= v_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      aft_r   <= AFT_NONE;
      fill_r  <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      cnt_r   <= '0;
      h_r     <= shs_pkg::IV;
    end else begin
      state_r <= state_nxt;
      aft_r   <= aft_nxt;
      fill_r  <= fill_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      h_r     <= h_nxt;
    end
  end

  `SHS_ASSERT(a_rnd_idle, (state_r != S_RND) |-> (rnd_r == 6'd0), "round count off outside rounds")
  `SHS_ASSERT(a_idx_idle, (state_r != S_OUT) |-> (idx_r == 3'd0), "word index off outside output")
  `SHS_ASSERT(a_last_done, (o_push && o_word.last_word) |=> (state_r == S_LOAD && fill_r == 6'd0), "no return to load after digest")
  `SHS_ASSERT(a_fin_after, (state_r == S_RND && rnd_r == 6'd63) |=> (state_r == S_FIN), "rounds did not finish")
endmodule

// ===== hdl/sha256_stream_hasher_top.sv =====
// Top level of the SHA-256 stream hasher: input queue, hash engine, digest queue.
// Usage:
//   Input channel: drive in_msg_byte, in_byte_valid, in_end_of_message with
//   in_push; a transfer happens on a clock edge with in_push high and in_full
//   low. An item with byte_valid set adds one byte; end_of_message closes the
//   message (after the byte, if any). Items with neither flag are dropped.
//   Result channel: while out_empty is low, the oldest digest word sits on
//   out_digest_word/out_word_index/out_last_word; raise out_pop to transfer it.
//   Each message yields eight words, index 0 first, out_last_word on word 7.
// Timing:
//   The engine writes each byte into the current block; every 64th byte starts
//   the round loop (one round per cycle through a single round unit) and the
//   chaining add. End of message runs a padding step, then rounds and chaining
//   add per final block (one or two blocks; a second block is preceded by a step
//   loading the length words), then words leave at one per cycle while the result queue has room.
//   The input queue absorbs QUEUE_DEPTH items while the engine is busy.
// Reset (rst_n low, synchronous): both queues empty, chaining state back to the
//   initial hash values, byte count and block fill cleared.
// Receiver stall: the engine holds the next digest word until the result queue
//   has room; the input queue fills behind it and in_full then rises.
module sha256_stream_hasher_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  input  logic        in_push,
  output logic        in_full,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        out_empty,
  input  logic        out_pop
);
  shs_pkg::item_t  in_item, q_item;
  shs_pkg::dword_t o_word, out_word;
  logic            q_push, q_empty, q_pop;
  logic            o_full, o_push;

  // Classify: only items that carry a byte or end a message reach the engine.
  assign in_item = '{msg_byte: in_msg_byte, byte_valid: in_byte_valid,
                     end_of_message: in_end_of_message};
  assign q_push  = in_push && (in_byte_valid || in_end_of_message);

  shs_fifo #(
    .WIDTH ($bits(shs_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (in_item),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  shs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_word  (o_word)
  );

  // Hold finished words here so the engine can advance while the receiver waits.
  shs_fifo #(
    .WIDTH ($bits(shs_pkg::dword_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .wdata (o_word),
    .full  (o_full),
    .pop   (out_pop),
    .rdata (out_word),
    .empty (out_empty)
  );

  assign out_digest_word = out_word.digest_word;
  assign out_word_index  = out_word.word_index;
  assign out_last_word   = out_word.last_word;
endmodule

// ===== bench/sha256_stream_hasher_checker.sv =====
// Checker for the SHA-256 stream hasher: predicts digests from input transfers, compares output words.
`timescale 1ns / 1ps
module sha256_stream_hasher_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  input  logic        out_empty,
  input  logic        out_pop,
  output int          fail_count,
  output int          pending_words
);
  logic [31:0]     hash_state [8];
  logic [7:0]      block_bytes [64];
  int unsigned     block_fill;
  logic [60:0]     byte_count;
  shs_pkg::dword_t digest_queue [$];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2, a15, a2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        a15 = w[(t-15) & 15];
        a2  = w[(t-2) & 15];
        wt = w[t & 15] + (ror32(a15, 7) ^ ror32(a15, 18) ^ (a15 >> 3)) + w[(t-7) & 15]
           + (ror32(a2, 17) ^ ror32(a2, 19) ^ (a2 >> 10));
        w[t & 15] = wt;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shs_pkg::RK[t] + wt;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = shs_pkg::IV[i];
    block_fill = 0;
    byte_count = '0;
  endtask

  // Fold one input transfer into the running hash; queue 8 words at end of message.
  task automatic absorb_item(input logic [7:0] b, input logic bv, input logic eom);
    logic [63:0] bit_len;
    shs_pkg::dword_t d;
    if (bv) begin
      block_bytes[block_fill] = b;
      block_fill++;
      byte_count++;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (eom) begin
      block_bytes[block_fill] = shs_pkg::PAD_BYTE;
      for (int i = block_fill + 1; i < 64; i++) block_bytes[i] = 8'h00;
      if (block_fill >= 56) begin
        compress_block();
        for (int i = 0; i < 56; i++) block_bytes[i] = 8'h00;
      end
      bit_len = {byte_count, 3'b000};
      for (int i = 0; i < 8; i++) block_bytes[63 - i] = bit_len[8*i +: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash_state[i];
        d.word_index = 3'(i);
        d.last_word = (i == 7);
        digest_queue.push_back(d);
      end
      restart_message();
    end
  endtask

  always @(posedge clk) begin
    shs_pkg::dword_t want;
    if (!rst_n) begin
      restart_message();
      digest_queue.delete();
      fail_count = 0;
      pending_words = 0;
    end else begin
      if (in_push && !in_full)
        absorb_item(in_msg_byte, in_byte_valid, in_end_of_message);
      if (out_pop && !out_empty) begin
        if (digest_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word: digest %h index %0d last %b",
                     out_digest_word, out_word_index, out_last_word);
        end else begin
          want = digest_queue.pop_front();
          if (want.digest_word !== out_digest_word || want.word_index !== out_word_index ||
              want.last_word !== out_last_word) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %h/%0d/%b got %h/%0d/%b",
                       want.digest_word, want.word_index, want.last_word,
                       out_digest_word, out_word_index, out_last_word);
          end
        end
      end
      pending_words = digest_queue.size();
    end
  end
endmodule

// ===== bench/sha256_stream_hasher_top_tb.sv =====
// Testbench top for the SHA-256 stream hasher: stimulus, idling and verdict.
`timescale 1ns / 1ps
module sha256_stream_hasher_top_tb;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [7:0]  in_msg_byte = '0;
  logic        in_byte_valid = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        drain_on = 1'b0;
  int          fail_count;
  int          pending_words;

  always #5 clk = ~clk;

  sha256_stream_hasher_top u_dut (
    .clk, .rst_n, .in_msg_byte, .in_byte_valid, .in_end_of_message, .in_push, .in_full,
    .out_digest_word, .out_word_index, .out_last_word, .out_empty, .out_pop
  );

  sha256_stream_hasher_checker u_checker (
    .clk, .rst_n, .in_msg_byte, .in_byte_valid, .in_end_of_message, .in_push, .in_full,
    .out_digest_word, .out_word_index, .out_last_word, .out_empty, .out_pop,
    .fail_count, .pending_words
  );

  // Mostly short gaps, now and then a long one, with runs of none at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drive one item at the falling edge, hold it until the transfer happens.
  // Push stays high on return so a following item can go out with no gap.
  task automatic send_item(input logic [7:0] b, input logic bv, input logic eom);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_msg_byte <= b;
    in_byte_valid <= bv;
    in_end_of_message <= eom;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  // Send a whole message of len random bytes, ending on a byte or an empty marker.
  task automatic send_message(input int len, input bit empty_end);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom_range(0, 255)), 1'b1, (!empty_end && i == len - 1));
    if (empty_end || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Receiver: pop with random stalls while draining is on.
  always @(negedge clk) begin
    if (drain_on && $urandom_range(0, 99) < 8) begin
      out_pop <= 1'b0;
      repeat ($urandom_range(5, 40)) @(negedge clk);
    end else begin
      out_pop <= drain_on && ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    #2_000_000;
    $display("sha256_stream_hasher_top_tb NOT OK");
    $finish;
  end

  initial begin
    int sent;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    drain_on <= 1'b1;

    // Directed: empty message, byte-and-end, idle items, extreme bytes.
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);

    // Hold off until every digest word is back.
    in_push <= 1'b0;
    while (pending_words != 0) @(negedge clk);

    // Padding boundaries: 56 bytes need two blocks, 64 end with a full block.
    send_message(56, 1'b0);
    send_message(64, 1'b0);

    sent = 0;
    while (sent < 40) begin
      int len;
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        continue;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
      send_message(len, 1'($urandom_range(0, 1)));
      sent += len + 1;
    end

    in_push <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending_words == 0)
      $display("sha256_stream_hasher_top_tb OK");
    else
      $display("sha256_stream_hasher_top_tb NOT OK");
    $finish;
  end
endmodule
